[design/life_like_automaton_row_step_assert.svh]
// Assertion macros shared by the checker file of the row step block.
`ifndef LIFE_LIKE_AUTOMATON_ROW_STEP_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_ROW_STEP_ASSERT_SVH

// Clocked on clock, switched off while reset is high.
`define LLA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked on clock, checked during reset too.
`define LLA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/lla_pkg.sv]
// Package: widths, register indexes, rule struct and row mask helper.
`default_nettype none

package lla_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int ROW_WIDTH_W = 7;
   localparam int RULE_W      = 9;
   localparam int COUNT_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [RULE_W-1:0]      BIRTH_RESET     = RULE_W'(8);
   localparam logic [RULE_W-1:0]      SURVIVAL_RESET  = RULE_W'(12);
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(MAX_WIDTH);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIRTH_MASK    = 2'd0,
      CSR_SURVIVAL_MASK = 2'd1,
      CSR_ROW_WIDTH     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RULE_W-1:0] birth;
      logic [RULE_W-1:0] survival;
   } rule_type;

   // Cells at or above the row width are forced dead.
   function automatic logic [MAX_WIDTH-1:0] width_mask(input logic [ROW_WIDTH_W-1:0] width);
      logic [MAX_WIDTH-1:0] mask;
      mask = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         mask[i] = (ROW_WIDTH_W'(i) < width);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

[design/lla_req_if.sv]
// Interface: input row channel.
`default_nettype none

interface lla_req_if import lla_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAX_WIDTH-1:0] row_cells;
   logic                 last_row;

   modport source (output valid, output row_cells, output last_row, input ready);
   modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

`default_nettype wire

[design/lla_rsp_if.sv]
// Interface: next-generation row channel.
`default_nettype none

interface lla_rsp_if import lla_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAX_WIDTH-1:0] next_row;
   logic                 last_out;

   modport source (output valid, output next_row, output last_out, input ready);
   modport sink   (input valid, input next_row, input last_out, output ready);
endinterface

`default_nettype wire

[design/lla_csr_if.sv]
// Interface: configuration register write channel.
`default_nettype none

interface lla_csr_if import lla_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/lla_evolve.sv]
// Neighbor count and birth/survival rule for all cells of one row in parallel.
`default_nettype none

module lla_evolve import lla_pkg::*; (
   input  logic [MAX_WIDTH-1:0] up,
   input  logic [MAX_WIDTH-1:0] mid,
   input  logic [MAX_WIDTH-1:0] down,
   input  logic [MAX_WIDTH-1:0] mask,
   input  rule_type             rule,
   output logic [MAX_WIDTH-1:0] next_row
);

   logic [MAX_WIDTH+1:0] up_pad;
   logic [MAX_WIDTH+1:0] mid_pad;
   logic [MAX_WIDTH+1:0] down_pad;

   // one dead cell on each side of the row
   assign up_pad   = {1'b0, up & mask, 1'b0};
   assign mid_pad  = {1'b0, mid & mask, 1'b0};
   assign down_pad = {1'b0, down & mask, 1'b0};

   always_comb begin
      logic [COUNT_W-1:0] count;
      logic [RULE_W-1:0]  sel;
      next_row = '0;
      for (int x = 0; x < MAX_WIDTH; x++) begin
         count = {3'b000, up_pad[x]}   + {3'b000, up_pad[x+1]}   + {3'b000, up_pad[x+2]}
               + {3'b000, mid_pad[x]}                            + {3'b000, mid_pad[x+2]}
               + {3'b000, down_pad[x]} + {3'b000, down_pad[x+1]} + {3'b000, down_pad[x+2]};
         sel = mid_pad[x+1] ? rule.survival : rule.birth;
         next_row[x] = sel[count] & mask[x];
      end
   end

endmodule

`default_nettype wire

[design/life_like_automaton_row_step.sv]
// Top level: one generation of a life-like automaton over a stream of rows.
// Rows enter top to bottom on req_ch, one row per transaction, and one row per cycle is taken
// while the result side keeps up and no bottom row waits for its second pass. Each
// next-generation row leaves on rsp_ch once the row below it has arrived; the bottom row of
// a frame (last_row set) yields two result transactions, its upper neighbor and itself
// with last_out set, and since both go through the one shared neighbor-count unit that row
// occupies it for two passes. The row that completes a result is first held in the staging
// register, and the result then waits in the result register; the second result of a
// bottom row comes from the same staged rows. A single-row frame gives one result. Cells
// outside the grid and at or above row_width are dead. Configuration writes on csr_ch are
// always taken, and are meant to happen between frames with the block drained.
`default_nettype none

module life_like_automaton_row_step import lla_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lla_req_if.sink   req_ch,
   lla_rsp_if.source rsp_ch,
   lla_csr_if.sink   csr_ch
);

   // configuration
   logic [RULE_W-1:0]      birth_mask_ff, birth_mask_in;
   logic [RULE_W-1:0]      survival_mask_ff, survival_mask_in;
   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;

   // row window
   logic [MAX_WIDTH-1:0]   row_above_ff, row_above_in;
   logic [MAX_WIDTH-1:0]   row_middle_ff, row_middle_in;
   logic                   row_held_ff, row_held_in;

   // staging register
   logic                   st_valid_ff, st_valid_in;
   logic                   st_need_a_ff, st_need_a_in;
   logic                   st_need_b_ff, st_need_b_in;
   logic [MAX_WIDTH-1:0]   st_up_ff, st_up_in;
   logic [MAX_WIDTH-1:0]   st_mid_ff, st_mid_in;
   logic [MAX_WIDTH-1:0]   st_down_ff, st_down_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [MAX_WIDTH-1:0]   out_row_ff, out_row_in;
   logic                   out_last_ff, out_last_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   st_fire;
   logic                   st_done;
   logic [MAX_WIDTH-1:0]   wmask;
   logic [MAX_WIDTH-1:0]   row_in;
   logic [MAX_WIDTH-1:0]   ev_up;
   logic [MAX_WIDTH-1:0]   ev_mid;
   logic [MAX_WIDTH-1:0]   ev_down;
   logic [MAX_WIDTH-1:0]   ev_row;
   rule_type               rule;

   assign wmask    = width_mask(row_width_ff);
   assign row_in   = req_ch.row_cells & wmask;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign st_fire  = st_valid_ff && out_free;
   // a bottom row with an upper neighbor needs two passes
   assign st_done  = st_fire && !(st_need_a_ff && st_need_b_ff);

   assign req_ch.ready    = !st_valid_ff || st_done;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.next_row = out_row_ff;
   assign rsp_ch.last_out = out_last_ff;

   assign rule.birth    = birth_mask_ff;
   assign rule.survival = survival_mask_ff;

   // first pass: row above the incoming one; second pass: the bottom row itself
   assign ev_up   = st_need_a_ff ? st_up_ff   : st_mid_ff;
   assign ev_mid  = st_need_a_ff ? st_mid_ff  : st_down_ff;
   assign ev_down = st_need_a_ff ? st_down_ff : '0;

   lla_evolve u_evolve (
      .up       (ev_up),
      .mid      (ev_mid),
      .down     (ev_down),
      .mask     (wmask),
      .rule     (rule),
      .next_row (ev_row)
   );

   always_comb begin
      birth_mask_in    = birth_mask_ff;
      survival_mask_in = survival_mask_ff;
      row_width_in     = row_width_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_BIRTH_MASK:    birth_mask_in    = csr_ch.data;
            CSR_SURVIVAL_MASK: survival_mask_in = csr_ch.data;
            CSR_ROW_WIDTH:     row_width_in     = csr_ch.data[ROW_WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      row_above_in  = row_above_ff;
      row_middle_in = row_middle_ff;
      row_held_in   = row_held_ff;
      if (req_fire) begin
         if (req_ch.last_row) begin
            row_above_in  = '0;
            row_middle_in = '0;
            row_held_in   = 1'b0;
         end else begin
            row_above_in  = row_middle_ff;
            row_middle_in = row_in;
            row_held_in   = 1'b1;
         end
      end
   end

   always_comb begin
      st_valid_in  = st_valid_ff;
      st_need_a_in = st_need_a_ff;
      st_need_b_in = st_need_b_ff;
      st_up_in     = st_up_ff;
      st_mid_in    = st_mid_ff;
      st_down_in   = st_down_ff;
      if (req_fire) begin
         st_valid_in  = row_held_ff || req_ch.last_row;
         st_need_a_in = row_held_ff;
         st_need_b_in = req_ch.last_row;
         st_up_in     = row_above_ff;
         st_mid_in    = row_middle_ff;
         st_down_in   = row_in;
      end else if (st_done) begin
         st_valid_in = 1'b0;
      end else if (st_fire) begin
         st_need_a_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      if (st_fire) begin
         out_valid_in = 1'b1;
         out_row_in   = ev_row;
         out_last_in  = !st_need_a_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_mask_ff    <= BIRTH_RESET;
         survival_mask_ff <= SURVIVAL_RESET;
         row_width_ff     <= ROW_WIDTH_RESET;
         row_above_ff     <= '0;
         row_middle_ff    <= '0;
         row_held_ff      <= 1'b0;
         st_valid_ff      <= 1'b0;
         st_need_a_ff     <= 1'b0;
         st_need_b_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         birth_mask_ff    <= birth_mask_in;
         survival_mask_ff <= survival_mask_in;
         row_width_ff     <= row_width_in;
         row_above_ff     <= row_above_in;
         row_middle_ff    <= row_middle_in;
         row_held_ff      <= row_held_in;
         st_valid_ff      <= st_valid_in;
         st_need_a_ff     <= st_need_a_in;
         st_need_b_ff     <= st_need_b_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_up_ff    <= st_up_in;
      st_mid_ff   <= st_mid_in;
      st_down_ff  <= st_down_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

[design/lla_checker.sv]
// Checker on the top-level ports, bound to the row step block.
`default_nettype none

`include "life_like_automaton_row_step_assert.svh"

module lla_checker import lla_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_last_row,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MAX_WIDTH-1:0] rsp_next_row,
   input logic                 rsp_last_out,
   input logic                 csr_ready
);

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_row) && $stable(rsp_last_out);
   endproperty

   property p_last_row_staged;
      req_valid && req_ready && req_last_row |=> !req_ready || !rsp_valid || rsp_ready;
   endproperty

   // no result comes out of reset
   `LLA_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp valid after reset")

   // a stalled result transaction keeps its payload
   `LLA_ASSERT(a_rsp_hold, p_rsp_hold, "rsp changed while stalled")

   // configuration writes are never stalled
   `LLA_ASSERT(a_csr_ready, csr_ready, "csr ready dropped")

   // a bottom row is staged on acceptance, so no row can follow it at once
   // unless the result side is free to take its first result
   `LLA_ASSERT(a_last_row_staged, p_last_row_staged, "row accepted behind a blocked bottom row")

endmodule

bind life_like_automaton_row_step lla_checker u_lla_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_last_row (req_ch.last_row),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_next_row (rsp_ch.next_row),
   .rsp_last_out (rsp_ch.last_out),
   .csr_ready    (csr_ch.ready)
);

`default_nettype wire
